### src/cle_pkg.sv
package cle_pkg;

    // command codes passed from the front to the back
    localparam logic [2:0] OP_PRINT  = 3'd0;
    localparam logic [2:0] OP_ERASE  = 3'd1;
    localparam logic [2:0] OP_CLEAR  = 3'd2;
    localparam logic [2:0] OP_RECALL = 3'd3;
    localparam logic [2:0] OP_ENTER  = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_LINE = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    // character codes
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_UPPERO = 8'h4F;
    localparam logic [7:0] CH_UPPERA = 8'h41;
    localparam logic [7:0] CH_UPPERB = 8'h42;
    localparam logic [7:0] CH_LOWERC = 8'h63;

    typedef struct packed {
        logic [2:0] op;
        logic [6:0] ch;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } res_t;

    // prompt text "cmd>"
    function automatic logic [7:0] prompt_char(input logic [1:0] pos);
        logic [7:0] c;
        case (pos)
            2'd0:    c = CH_LOWERC;
            2'd1:    c = 8'h6D;
            2'd2:    c = 8'h64;
            default: c = 8'h3E;
        endcase
        return c;
    endfunction

endpackage

### src/console_line_editor.sv
// the first result of an item passes the command queue, the sequencer and the result queue
// before it shows on the result ports, where it can be popped
// the back sends one result per cycle while the result queue has room; a printable byte is
// echoed as it is taken, any other command is taken first and its results follow, and no
// new command is taken until the last result of the one before has been sent
// reset: rst_n is asynchronous active low; empties both queues, line, history and escape state
module console_line_editor #(
    parameter int LINE_LEN = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    // input side
    input  logic       push,
    output logic       full,
    input  logic [7:0] rx_byte,
    // result side
    output logic       empty,
    input  logic       pop,
    output logic [1:0] out_kind,
    output logic [7:0] out_byte,
    output logic       out_last
);

    localparam int CMD_W = $bits(cle_pkg::cmd_t);
    localparam int RES_W = $bits(cle_pkg::res_t);

    // front to back command queue
    logic          accept;
    logic          cmd_push;
    cle_pkg::cmd_t front_cmd;
    cle_pkg::cmd_t back_cmd;
    logic          cmd_empty;
    logic          cmd_pop;

    // back to result queue
    logic          res_push;
    logic          res_full;
    cle_pkg::res_t back_res;
    cle_pkg::res_t head_res;

    // an item is taken whenever the command queue has room, even if it
    // only moves the escape decoder and produces no command
    assign accept = push && !full;

    // escape decoder and byte classifier
    cle_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .rx_byte  (rx_byte),
        .cmd_push (cmd_push),
        .cmd      (front_cmd)
    );

    // short command queue that lets the front keep taking items while the
    // back is busy with a long echo sequence
    cle_fifo #(
        .DATA_W (CMD_W),
        .DEPTH  (2)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (front_cmd),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (back_cmd),
        .empty (cmd_empty)
    );

    // sequencer owning the line and history stores
    cle_back #(
        .LINE_LEN (LINE_LEN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (back_cmd),
        .cmd_pop   (cmd_pop),
        .out_full  (res_full),
        .out_push  (res_push),
        .res       (back_res)
    );

    // result queue decouples the sequencer from the consumer
    cle_fifo #(
        .DATA_W (RES_W),
        .DEPTH  (2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (back_res),
        .full  (res_full),
        .pop   (pop),
        .rdata (head_res),
        .empty (empty)
    );

    assign out_kind = head_res.kind;
    assign out_byte = head_res.data;
    assign out_last = head_res.last;

endmodule

### src/cle_fifo.sv
module cle_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] wdata,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] rdata,
    output logic              empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wptr_reg;
    logic [PTR_W-1:0]  wptr_next;
    logic [PTR_W-1:0]  rptr_reg;
    logic [PTR_W-1:0]  rptr_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wptr_reg] <= wdata;
        end
    end

endmodule

### src/cle_front.sv
module cle_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    rx_byte,
    output logic          cmd_push,
    output cle_pkg::cmd_t cmd
);

    localparam logic [1:0] PH_NORMAL = 2'd0;
    localparam logic [1:0] PH_ESC    = 2'd1;
    localparam logic [1:0] PH_CSI    = 2'd2;

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic       has_cmd;
    logic [2:0] op;
    logic       is_param;

    assign is_param = ((rx_byte >= cle_pkg::CH_ZERO) && (rx_byte <= cle_pkg::CH_NINE))
                      || (rx_byte == cle_pkg::CH_SEMI);

    always_comb
    begin
        phase_next = phase_reg;
        has_cmd    = 1'b0;
        op         = cle_pkg::OP_PRINT;
        unique case (phase_reg)
            PH_CSI:
            begin
                if (!is_param)
                begin
                    phase_next = PH_NORMAL;
                    if (rx_byte == cle_pkg::CH_UPPERA)
                    begin
                        has_cmd = 1'b1;
                        op      = cle_pkg::OP_RECALL;
                    end
                    else if (rx_byte == cle_pkg::CH_UPPERB)
                    begin
                        has_cmd = 1'b1;
                        op      = cle_pkg::OP_CLEAR;
                    end
                end
            end
            PH_ESC:
            begin
                phase_next = ((rx_byte == cle_pkg::CH_LBRK) || (rx_byte == cle_pkg::CH_UPPERO))
                             ? PH_CSI : PH_NORMAL;
            end
            default:
            begin
                phase_next = PH_NORMAL;
                if (rx_byte == cle_pkg::CH_ESC)
                begin
                    phase_next = PH_ESC;
                end
                else if (rx_byte == cle_pkg::CH_CR)
                begin
                    has_cmd = 1'b1;
                    op      = cle_pkg::OP_ENTER;
                end
                else if ((rx_byte == cle_pkg::CH_BS) || (rx_byte == cle_pkg::CH_DEL))
                begin
                    has_cmd = 1'b1;
                    op      = cle_pkg::OP_ERASE;
                end
                else if ((rx_byte >= cle_pkg::CH_SP) && (rx_byte < cle_pkg::CH_DEL))
                begin
                    has_cmd = 1'b1;
                    op      = cle_pkg::OP_PRINT;
                end
            end
        endcase
    end

    assign cmd_push = accept && has_cmd;
    assign cmd.op   = op;
    assign cmd.ch   = rx_byte[6:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_NORMAL;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

### src/cle_back.sv
module cle_back #(
    parameter int LINE_LEN = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_empty,
    input  cle_pkg::cmd_t cmd,
    output logic          cmd_pop,
    input  logic          out_full,
    output logic          out_push,
    output cle_pkg::res_t res
);

    localparam int DEPTH = LINE_LEN - 1;
    localparam int CNT_W = $clog2(LINE_LEN);
    localparam int IDX_W = $clog2(LINE_LEN - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ERASE  = 3'd1;
    localparam logic [2:0] S_RECALL = 3'd2;
    localparam logic [2:0] S_CR     = 3'd3;
    localparam logic [2:0] S_LF     = 3'd4;
    localparam logic [2:0] S_LINE   = 3'd5;
    localparam logic [2:0] S_END    = 3'd6;
    localparam logic [2:0] S_PROMPT = 3'd7;

    localparam logic [1:0] ER_ONE    = 2'd0;
    localparam logic [1:0] ER_ALL    = 2'd1;
    localparam logic [1:0] ER_RECALL = 2'd2;

    logic [6:0]       line_mem [DEPTH];
    logic [6:0]       hist_mem [DEPTH];

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [1:0]       mode_reg;
    logic [1:0]       mode_next;
    logic [1:0]       sub_reg;
    logic [1:0]       sub_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] hist_reg;
    logic [CNT_W-1:0] hist_next;

    logic             line_we;
    logic [IDX_W-1:0] line_waddr;
    logic [6:0]       line_wdata;
    logic             hist_we;
    logic             erase_done;
    logic             to_recall;
    logic             idx_at_end;

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        sub_next   = sub_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        hist_next  = hist_reg;
        cmd_pop    = 1'b0;
        out_push   = 1'b0;
        res.kind   = cle_pkg::KIND_ECHO;
        res.data   = cle_pkg::CH_BS;
        res.last   = 1'b0;
        line_we    = 1'b0;
        line_waddr = idx_reg;
        line_wdata = hist_mem[idx_reg];
        hist_we    = 1'b0;
        erase_done = (mode_reg == ER_ONE) || (count_reg == CNT_W'(1));
        to_recall  = (mode_reg == ER_RECALL) && (hist_reg != '0);
        idx_at_end = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    case (cmd.op)
                        cle_pkg::OP_PRINT:
                        begin
                            if (!out_full)
                            begin
                                cmd_pop  = 1'b1;
                                out_push = 1'b1;
                                res.data = {1'b0, cmd.ch};
                                res.last = 1'b1;
                                if (count_reg < CNT_W'(DEPTH))
                                begin
                                    line_we    = 1'b1;
                                    line_waddr = count_reg[IDX_W-1:0];
                                    line_wdata = cmd.ch;
                                    count_next = count_reg + 1'b1;
                                end
                            end
                        end
                        cle_pkg::OP_ERASE:
                        begin
                            cmd_pop   = 1'b1;
                            mode_next = ER_ONE;
                            sub_next  = '0;
                            if (count_reg != '0)
                            begin
                                state_next = S_ERASE;
                            end
                        end
                        cle_pkg::OP_CLEAR:
                        begin
                            cmd_pop   = 1'b1;
                            mode_next = ER_ALL;
                            sub_next  = '0;
                            if (count_reg != '0)
                            begin
                                state_next = S_ERASE;
                            end
                        end
                        cle_pkg::OP_RECALL:
                        begin
                            cmd_pop   = 1'b1;
                            mode_next = ER_RECALL;
                            sub_next  = '0;
                            idx_next  = '0;
                            if (count_reg != '0)
                            begin
                                state_next = S_ERASE;
                            end
                            else if (hist_reg != '0)
                            begin
                                state_next = S_RECALL;
                            end
                        end
                        cle_pkg::OP_ENTER:
                        begin
                            cmd_pop    = 1'b1;
                            state_next = S_CR;
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_ERASE:
            begin
                if (!out_full)
                begin
                    out_push = 1'b1;
                    res.data = (sub_reg == 2'd1) ? cle_pkg::CH_SP : cle_pkg::CH_BS;
                    if (sub_reg == 2'd2)
                    begin
                        sub_next   = '0;
                        count_next = count_reg - 1'b1;
                        if (erase_done)
                        begin
                            res.last   = !to_recall;
                            idx_next   = '0;
                            state_next = to_recall ? S_RECALL : S_IDLE;
                        end
                    end
                    else
                    begin
                        sub_next = sub_reg + 1'b1;
                    end
                end
            end
            S_RECALL:
            begin
                idx_at_end = (CNT_W'(idx_reg) == CNT_W'(hist_reg - 1'b1));
                if (!out_full)
                begin
                    out_push = 1'b1;
                    res.data = {1'b0, hist_mem[idx_reg]};
                    res.last = idx_at_end;
                    line_we  = 1'b1;
                    if (idx_at_end)
                    begin
                        idx_next   = '0;
                        count_next = hist_reg;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_CR:
            begin
                if (!out_full)
                begin
                    out_push   = 1'b1;
                    res.data   = cle_pkg::CH_CR;
                    state_next = S_LF;
                end
            end
            S_LF:
            begin
                if (!out_full)
                begin
                    out_push   = 1'b1;
                    res.data   = cle_pkg::CH_LF;
                    idx_next   = '0;
                    state_next = (count_reg != '0) ? S_LINE : S_END;
                end
            end
            S_LINE:
            begin
                idx_at_end = (CNT_W'(idx_reg) == CNT_W'(count_reg - 1'b1));
                if (!out_full)
                begin
                    out_push = 1'b1;
                    res.kind = cle_pkg::KIND_LINE;
                    res.data = {1'b0, line_mem[idx_reg]};
                    hist_we  = 1'b1;
                    if (idx_at_end)
                    begin
                        idx_next   = '0;
                        hist_next  = count_reg;
                        state_next = S_END;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_END:
            begin
                if (!out_full)
                begin
                    out_push   = 1'b1;
                    res.kind   = cle_pkg::KIND_END;
                    res.data   = 8'(count_reg);
                    count_next = '0;
                    sub_next   = '0;
                    state_next = S_PROMPT;
                end
            end
            default:
            begin
                if (!out_full)
                begin
                    out_push = 1'b1;
                    res.data = cle_pkg::prompt_char(sub_reg);
                    if (sub_reg == 2'd3)
                    begin
                        res.last   = 1'b1;
                        sub_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        sub_next = sub_reg + 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= ER_ONE;
            sub_reg   <= '0;
            idx_reg   <= '0;
            count_reg <= '0;
            hist_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            sub_reg   <= sub_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
            hist_reg  <= hist_next;
        end
    end

    // line and history stores, entries only read below their count
    always_ff @(posedge clk)
    begin
        if (line_we)
        begin
            line_mem[line_waddr] <= line_wdata;
        end
        if (hist_we)
        begin
            hist_mem[idx_reg] <= line_mem[idx_reg];
        end
    end

endmodule

### src/cle_checker.sv
module cle_checker #(
    parameter int LINE_LEN = 16
) (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [1:0] out_kind,
    input logic [7:0] out_byte,
    input logic       out_last
);

    // only three kinds exist
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (out_kind == cle_pkg::KIND_ECHO || out_kind == cle_pkg::KIND_LINE
                    || out_kind == cle_pkg::KIND_END))
        else $error("unknown result kind");

    // line bytes and the end marker are never marked last, since the prompt follows them
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_kind != cle_pkg::KIND_ECHO) |-> !out_last)
        else $error("line result marked last");

    // the end marker carries a length the line store can hold
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_kind == cle_pkg::KIND_END) |-> (out_byte <= 8'(LINE_LEN - 1)))
        else $error("line length out of range");

    // the prompt starts right after the end marker
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && out_kind == cle_pkg::KIND_END) |=>
        (empty || (out_kind == cle_pkg::KIND_ECHO && out_byte == cle_pkg::CH_LOWERC)))
        else $error("prompt does not follow end marker");

    // a waiting result holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_kind)))
        else $error("waiting result changed");

endmodule

bind console_line_editor cle_checker #(
    .LINE_LEN (LINE_LEN)
) u_cle_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .out_kind (out_kind),
    .out_byte (out_byte),
    .out_last (out_last)
);
